// File: hw/rtl/kef_pkg.sv
`timescale 1ns / 1ps
package kef_pkg;

  // default queue depth
  localparam int unsigned QueueDepth = 16;

  // field widths
  localparam int unsigned ActionW  = 2;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CountOutW = 5;

  // stream widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 24;

  // message codes
  localparam logic [WordW-1:0] MsgChar    = 32'h0000_0102;
  localparam logic [WordW-1:0] MsgKeyDown = 32'h0000_0100;
  localparam logic [WordW-1:0] ClipChar   = 32'h0000_0016;

  typedef enum logic [ActionW-1:0] {
    ACT_DELIVER = 2'd0,
    ACT_POP     = 2'd1,
    ACT_ENABLE  = 2'd2
  } action_e;

  typedef struct packed {
    logic             is_key;
    logic [CodeW-1:0] code;
  } entry_t;

  // request to the queue for one item
  typedef struct packed {
    logic   push;
    logic   pop;
    logic   clear;
    entry_t wdata;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // registered result without the popped entry
  typedef struct packed {
    logic                 event_valid;
    logic                 accepted;
    logic                 dropped_full;
    logic [CountOutW-1:0] queue_count;
    logic                 clipboard_flag;
  } result_t;

  // navigation and edit keys that pass the key-down filter
  function automatic logic is_listed_key(input logic [WordW-1:0] code);
    logic hit;
    unique case (code)
      32'h26, 32'h28, 32'h25, 32'h27,
      32'h24, 32'h09, 32'h23, 32'h2e,
      32'h2d, 32'h14, 32'h21, 32'h22: hit = 1'b1;
      default:                        hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: hw/rtl/kef_queue.sv
`timescale 1ns / 1ps
module kef_queue #(
  parameter int unsigned QUEUE_DEPTH = kef_pkg::QueueDepth,
  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kef_pkg::queue_ctl_t  ctl_i,
  output kef_pkg::queue_stat_t stat_o,
  output logic [CntW-1:0]      count_next_o,
  output kef_pkg::entry_t      rdata_o
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  kef_pkg::entry_t mem [QUEUE_DEPTH];
  kef_pkg::entry_t rdata_q;

  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    rptr_d  = rptr_q;
    wptr_d  = wptr_q;
    count_d = count_q;
    priority if (ctl_i.clear) begin
      rptr_d  = '0;
      wptr_d  = '0;
      count_d = '0;
    end else if (ctl_i.push) begin
      wptr_d  = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      count_d = count_q + 1'b1;
    end else if (ctl_i.pop) begin
      rptr_d  = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  assign count_next_o = count_d;
  assign rdata_o      = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      count_q <= count_d;
    end
  end

  // storage has no reset; reads only follow the fill count
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wptr_q] <= ctl_i.wdata;
    end
    if (ctl_i.pop) begin
      rdata_q <= mem[rptr_q];
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !stat_o.full && !ctl_i.pop)
    else $error("push into full queue or with pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!stat_o.full && !stat_o.empty) |-> rptr_q != wptr_q)
    else $error("pointers meet while partly filled");
`endif

endmodule

// File: hw/rtl/key_event_filter_fifo.sv
`timescale 1ns / 1ps
// Keyboard message filter with an event queue.
// Input stream: one request per item. s_axis_tuser carries the action
// (deliver message, pop oldest event, set enable and empty queue),
// s_axis_tdata the message code, key parameter and enable bit.
// Output stream: exactly one result per request, in request order, with
// the popped event (kind in m_axis_tuser), accept/drop flags, the queue
// fill after the request and the sticky clipboard flag.
// The result is valid in the cycle after the request is taken.
// Throughput: one request per cycle while results are taken; the queue update
// and filter decode sit between the input handshake and one result register,
// and the queue storage is read through a register at the same edge.
// Reset: queue empty, filter disabled, clipboard flag clear; no output.
// Stall: while a result waits and m_axis_tready is low, s_axis_tready is
// low and the result holds; when it is taken a new request enters the
// same cycle.
module key_event_filter_fifo #(
  parameter int unsigned QUEUE_DEPTH = kef_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [31:0] message_code, [63:32] key_param, [64] enable_value, rest zero
  input  logic [kef_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [kef_pkg::ActionW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] event_valid, [8:1] event_code, [9] accepted, [10] dropped_full,
  // [15:11] queue_count, [16] clipboard_flag, rest zero
  output logic [kef_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] event_is_key
  output logic                          m_axis_tuser
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic                         in_fire;
  kef_pkg::action_e             action;
  logic [kef_pkg::WordW-1:0]    message_code;
  logic [kef_pkg::WordW-1:0]    key_param;
  logic                         enable_value;

  logic                         is_char, is_key, qualifies;
  kef_pkg::queue_ctl_t          ctl;
  kef_pkg::queue_stat_t         stat;
  logic [CntW-1:0]              count_next;
  kef_pkg::entry_t              rdata;

  logic                         enabled_q, enabled_d;
  logic                         clip_q, clip_d;
  logic                         out_valid_q;
  kef_pkg::result_t             res_q, res_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign action       = kef_pkg::action_e'(s_axis_tuser);
  assign message_code = s_axis_tdata[31:0];
  assign key_param    = s_axis_tdata[63:32];
  assign enable_value = s_axis_tdata[64];

  assign is_char = (message_code == kef_pkg::MsgChar);
  assign is_key  = (message_code == kef_pkg::MsgKeyDown) && kef_pkg::is_listed_key(key_param);

  always_comb begin
    ctl              = '0;
    ctl.wdata.is_key = !is_char;
    ctl.wdata.code   = key_param[kef_pkg::CodeW-1:0];
    qualifies        = 1'b0;
    enabled_d        = enabled_q;
    clip_d           = clip_q;
    if (in_fire) begin
      unique case (action)
        kef_pkg::ACT_DELIVER: begin
          qualifies = enabled_q && (is_char || is_key);
          ctl.push  = qualifies && !stat.full;
          if (enabled_q && is_char && key_param == kef_pkg::ClipChar) begin
            clip_d = 1'b1;
          end
        end
        kef_pkg::ACT_POP: begin
          ctl.pop = !stat.empty;
        end
        kef_pkg::ACT_ENABLE: begin
          ctl.clear = 1'b1;
          enabled_d = enable_value;
        end
        default: begin
        end
      endcase
    end
    res_d.event_valid    = ctl.pop;
    res_d.accepted       = ctl.push;
    res_d.dropped_full   = qualifies && stat.full;
    res_d.queue_count    = kef_pkg::CountOutW'(count_next);
    res_d.clipboard_flag = clip_d;
  end

  kef_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .count_next_o(count_next),
    .rdata_o     (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      enabled_q <= enabled_d;
      clip_q    <= clip_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  // popped entry fields read as zero unless a pop returned an event
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0,
                          res_q.clipboard_flag,
                          res_q.queue_count,
                          res_q.dropped_full,
                          res_q.accepted,
                          res_q.event_valid ? rdata.code : {kef_pkg::CodeW{1'b0}},
                          res_q.event_valid};
  assign m_axis_tuser  = res_q.event_valid && rdata.is_key;

`ifndef ASSERT_OFF
  a_clip_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_q |=> clip_q)
    else $error("clipboard flag cleared");

  a_disabled_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.push |-> enabled_q && action == kef_pkg::ACT_DELIVER)
    else $error("event queued while filter disabled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(res_q))
    else $error("result changed while stalled");
`endif

endmodule

// File: bench/key_event_filter_fifo_test.sv
`timescale 1ns / 1ps
module key_event_filter_fifo_test;

  localparam logic [kef_pkg::ActionW-1:0] ActSpare = 2'd3;
  localparam int unsigned TargetItems = 1400;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned MaxReports = 60;

  // up, down, left, right, home, tab, end, delete, insert, caps lock, page up, page down
  localparam logic [11:0][kef_pkg::WordW-1:0] NavKeys = {
    32'h26, 32'h28, 32'h25, 32'h27, 32'h24, 32'h09,
    32'h23, 32'h2e, 32'h2d, 32'h14, 32'h21, 32'h22
  };

  localparam int RxAlways = 0;
  localparam int RxRandom = 1;
  localparam int RxToggle = 2;
  localparam int RxRuns   = 3;

  typedef struct packed {
    bit                          event_valid;
    bit [kef_pkg::CodeW-1:0]     event_code;
    bit                          event_is_key;
    bit                          accepted;
    bit                          dropped_full;
    bit [kef_pkg::CountOutW-1:0] queue_count;
    bit                          clipboard_flag;
  } key_result_t;

  class event_fifo_mirror;
    bit [8:0]    held_events[$];
    bit          filter_on;
    bit          clip_requested;
    key_result_t pending_results[$];
    int unsigned mismatch_count;

    function bit is_nav_key(logic [kef_pkg::WordW-1:0] code);
      for (int i = 0; i < 12; i++) begin
        if (code == NavKeys[i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // work out the result of one accepted request
    function void apply_request(logic [kef_pkg::ActionW-1:0] act,
                                logic [kef_pkg::WordW-1:0] msg,
                                logic [kef_pkg::WordW-1:0] param, logic en);
      key_result_t r;
      bit          qualifies;
      bit [8:0]    entry;
      r = '0;
      qualifies = 1'b0;
      entry = {1'b0, param[7:0]};
      case (act)
        kef_pkg::ACT_DELIVER: begin
          if (filter_on) begin
            if (msg == kef_pkg::MsgChar) begin
              if (param == kef_pkg::ClipChar) clip_requested = 1'b1;
              qualifies = 1'b1;
            end else if (msg == kef_pkg::MsgKeyDown && is_nav_key(param)) begin
              entry[8] = 1'b1;
              qualifies = 1'b1;
            end
            if (qualifies) begin
              if (held_events.size() < kef_pkg::QueueDepth) begin
                held_events.push_back(entry);
                r.accepted = 1'b1;
              end else begin
                r.dropped_full = 1'b1;
              end
            end
          end
        end
        kef_pkg::ACT_POP: begin
          if (held_events.size() != 0) begin
            entry = held_events.pop_front();
            r.event_valid = 1'b1;
            r.event_code = entry[7:0];
            r.event_is_key = entry[8];
          end
        end
        kef_pkg::ACT_ENABLE: begin
          filter_on = en;
          held_events.delete();
        end
        default: ;
      endcase
      r.queue_count = kef_pkg::CountOutW'(held_events.size());
      r.clipboard_flag = clip_requested;
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [kef_pkg::OutDataW-1:0] data, logic is_key);
      key_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t mismatch result: expected none actual %0h", $time, data);
        return;
      end
      want = pending_results.pop_front();
      check_field("event_valid", 32'(want.event_valid), 32'(data[0]));
      check_field("event_code", 32'(want.event_code), 32'(data[8:1]));
      check_field("accepted", 32'(want.accepted), 32'(data[9]));
      check_field("dropped_full", 32'(want.dropped_full), 32'(data[10]));
      check_field("queue_count", 32'(want.queue_count), 32'(data[15:11]));
      check_field("clipboard_flag", 32'(want.clipboard_flag), 32'(data[16]));
      check_field("tdata padding", '0, 32'(data[kef_pkg::OutDataW-1:17]));
      check_field("event_is_key", 32'(want.event_is_key), 32'(is_key));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [kef_pkg::InDataW-1:0]  s_axis_tdata = '0;
  logic [kef_pkg::ActionW-1:0]  s_axis_tuser = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [kef_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tuser;

  event_fifo_mirror mirror = new();
  int unsigned      useful_items = 0;
  int unsigned      quiet_cycles = 0;
  int               rx_mode = RxAlways;
  int               rx_mode_left = 0;
  int               rx_stall_left = 0;

  key_event_filter_fifo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic send_request(input logic [kef_pkg::ActionW-1:0] act,
                              input logic [kef_pkg::WordW-1:0] msg,
                              input logic [kef_pkg::WordW-1:0] param, input logic en);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = {7'b0, en, param, msg};
    do @(posedge clk_i); while (!s_axis_tready);
    mirror.apply_request(act, msg, param, en);
    @(negedge clk_i);
  endtask

  task automatic idle_for(input int unsigned n);
    s_axis_tvalid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_random_item(input bit filling);
    int unsigned                  pick;
    logic [kef_pkg::ActionW-1:0]  act;
    logic [kef_pkg::WordW-1:0]    msg;
    logic [kef_pkg::WordW-1:0]    param;
    logic                         en;
    bit                           useful;
    pick = $urandom_range(0, 99);
    msg = $urandom();
    param = $urandom();
    en = 1'($urandom_range(0, 1));
    useful = 1'b1;
    if (pick < (filling ? 70 : 30)) begin
      act = kef_pkg::ACT_DELIVER;
      if ($urandom_range(0, 1)) begin
        msg = kef_pkg::MsgChar;
        case ($urandom_range(0, 4))
          0: param = kef_pkg::ClipChar;
          1, 2: param = $urandom_range(0, 255);
          default: ;
        endcase
      end else begin
        msg = kef_pkg::MsgKeyDown;
        case ($urandom_range(0, 5))
          0: ;
          // listed low byte under random upper bits
          1: param = {param[31:8], NavKeys[$urandom_range(0, 11)][7:0]};
          default: param = NavKeys[$urandom_range(0, 11)];
        endcase
      end
    end else if (pick < (filling ? 85 : 90)) begin
      act = kef_pkg::ACT_POP;
    end else if (pick < 97) begin
      useful = 1'b0;
      if (pick < 94) begin
        act = kef_pkg::ACT_DELIVER;
        // near miss on the key-down code
        if (pick[0]) msg = kef_pkg::MsgKeyDown ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        act = ActSpare;
      end
    end else begin
      act = kef_pkg::ACT_ENABLE;
      en = ($urandom_range(0, 4) != 0);
    end
    send_request(act, msg, param, en);
    if (useful) useful_items++;
  endtask

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(RxAlways, RxRuns);
      rx_mode_left = $urandom_range(20, 120);
    end
    rx_mode_left--;
    case (rx_mode)
      RxAlways: m_axis_tready = 1'b1;
      RxRandom: m_axis_tready = ($urandom_range(0, 3) != 0);
      RxToggle: m_axis_tready = ~m_axis_tready;
      default: begin
        if (rx_stall_left > 0) begin
          m_axis_tready = 1'b0;
          rx_stall_left--;
        end else begin
          m_axis_tready = 1'b1;
          if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(1, 12);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      mirror.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    bit          filling;
    int unsigned phase_left;
    int unsigned burst;
    filling = 1'b1;
    phase_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(kef_pkg::ACT_POP, '1, '1, 1'b1);                         // pop while empty
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, kef_pkg::ClipChar, 1'b1);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgKeyDown, NavKeys[0], 1'b0);
    send_request(ActSpare, '1, '1, 1'b1);
    send_request(kef_pkg::ACT_ENABLE, '1, '1, 1'b1);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, 32'h0, 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, 32'hffff_ffff, 1'b1);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, 32'h0000_0116, 1'b0);  // low byte only
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, kef_pkg::ClipChar, 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgKeyDown, NavKeys[11], 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgKeyDown, NavKeys[6], 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgKeyDown, 32'hffff_0026, 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgKeyDown, 32'h41, 1'b0);
    send_request(kef_pkg::ACT_DELIVER, 32'hffff_ffff, NavKeys[2], 1'b1);
    send_request(kef_pkg::ACT_DELIVER, 32'h0001_0102, 32'h61, 1'b0);
    send_request(ActSpare, 32'h0, 32'h0, 1'b0);
    repeat (5) send_request(kef_pkg::ACT_POP, 32'h0, 32'h0, 1'b0);
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, 32'h7a, 1'b0);
    send_request(kef_pkg::ACT_ENABLE, 32'h0, 32'h0, 1'b0);  // disable empties the queue
    send_request(kef_pkg::ACT_DELIVER, kef_pkg::MsgChar, 32'h7a, 1'b0);
    send_request(kef_pkg::ACT_ENABLE, 32'h0, 32'h0, 1'b1);

    while (useful_items < TargetItems) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (phase_left == 0) begin
          filling = ~filling;
          phase_left = $urandom_range(20, 60);
        end
        phase_left--;
        send_random_item(filling);
      end
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 5));
    end
    s_axis_tvalid = 1'b0;

    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mirror.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/kef_pkg.sv
hw/rtl/kef_queue.sv
hw/rtl/key_event_filter_fifo.sv
bench/key_event_filter_fifo_test.sv
